>>> design/tlpg_pkg.sv
// Shared types and constants for the thick line point generator.
package tlpg_pkg;

  localparam int unsigned COORD_BITS = 10;
  localparam int unsigned RADIUS_BITS = 8;
  localparam int unsigned CFG_BITS = 10;
  localparam int unsigned CFG_INDEX_BITS = 2;
  localparam int unsigned ACC_BITS = COORD_BITS + 1;

  localparam logic [CFG_BITS-1:0] ScreenWidthRst = CFG_BITS'(240);
  localparam logic [CFG_BITS-1:0] ScreenHeightRst = CFG_BITS'(320);

  typedef enum logic {
    CmdStart   = 1'b0,
    CmdAdvance = 1'b1
  } cmd_e;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    RegScreenWidth  = 2'd0,
    RegScreenHeight = 2'd1
  } cfg_reg_e;

  // Endpoints and brush radius carried by a start transfer.
  typedef struct packed {
    logic [COORD_BITS-1:0]  x1;
    logic [COORD_BITS-1:0]  y1;
    logic [COORD_BITS-1:0]  x2;
    logic [COORD_BITS-1:0]  y2;
    logic [RADIUS_BITS-1:0] radius;
  } line_start_t;

  // Current walker position and status as seen by the top level.
  typedef struct packed {
    logic                   active;
    logic                   last;
    logic [COORD_BITS-1:0]  x;
    logic [COORD_BITS-1:0]  y;
    logic [RADIUS_BITS-1:0] radius;
  } walk_status_t;

endpackage

>>> design/tlpg_bounds.sv
// Brush circle bounds test against the configured screen size.
module tlpg_bounds (
  input  logic [tlpg_pkg::COORD_BITS-1:0]  x_i,
  input  logic [tlpg_pkg::COORD_BITS-1:0]  y_i,
  input  logic [tlpg_pkg::RADIUS_BITS-1:0] radius_i,
  input  logic [tlpg_pkg::CFG_BITS-1:0]    width_i,
  input  logic [tlpg_pkg::CFG_BITS-1:0]    height_i,
  output logic                             visible_o
);

  localparam int unsigned SumBits = tlpg_pkg::ACC_BITS;

  logic [SumBits-1:0] x_far;
  logic [SumBits-1:0] y_far;
  logic [SumBits-1:0] r_ext;
  logic               off_screen;

  always_comb begin
    r_ext = SumBits'(radius_i);
    x_far = SumBits'(x_i) + r_ext;
    y_far = SumBits'(y_i) + r_ext;
    off_screen = (x_far > SumBits'(width_i)) || (SumBits'(x_i) < r_ext) ||
                 (y_far > SumBits'(height_i)) || (SumBits'(y_i) < r_ext);
    visible_o = !off_screen;
  end

endmodule

>>> design/tlpg_walker.sv
// Bresenham walker state: loads a line on start and steps one point per advance.
module tlpg_walker (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic                   advance_i,
  input  tlpg_pkg::line_start_t  line_i,
  output tlpg_pkg::walk_status_t status_o
);

  localparam int unsigned CB = tlpg_pkg::COORD_BITS;
  localparam int unsigned AB = tlpg_pkg::ACC_BITS;

  logic [CB-1:0]                   x_q, x_d, y_q, y_d;
  logic [AB-1:0]                   err_q, err_d;
  logic [CB-1:0]                   major_q, major_d, minor_q, minor_d;
  logic [AB-1:0]                   left_q, left_d;
  logic                            xneg_q, xneg_d, yneg_q, yneg_d, ymaj_q, ymaj_d;
  logic [tlpg_pkg::RADIUS_BITS-1:0] radius_q, radius_d;
  logic                            active_q, active_d;

  logic [CB-1:0] dx, dy;
  logic [AB-1:0] err_sum;
  logic          minor_step, step_x, step_y, last;

  assign last = (left_q <= AB'(1));

  always_comb begin
    x_d      = x_q;
    y_d      = y_q;
    err_d    = err_q;
    major_d  = major_q;
    minor_d  = minor_q;
    left_d   = left_q;
    xneg_d   = xneg_q;
    yneg_d   = yneg_q;
    ymaj_d   = ymaj_q;
    radius_d = radius_q;
    active_d = active_q;

    dx = (line_i.x2 >= line_i.x1) ? line_i.x2 - line_i.x1 : line_i.x1 - line_i.x2;
    dy = (line_i.y2 >= line_i.y1) ? line_i.y2 - line_i.y1 : line_i.y1 - line_i.y2;

    err_sum    = err_q + AB'(minor_q);
    minor_step = (err_sum >= AB'(major_q));
    step_x     = ymaj_q ? minor_step : 1'b1;
    step_y     = ymaj_q ? 1'b1 : minor_step;

    if (start_i) begin
      xneg_d   = (line_i.x2 < line_i.x1);
      yneg_d   = (line_i.y2 < line_i.y1);
      ymaj_d   = (dx < dy);
      major_d  = (dx < dy) ? dy : dx;
      minor_d  = (dx < dy) ? dx : dy;
      x_d      = line_i.x1;
      y_d      = line_i.y1;
      err_d    = AB'(major_d >> 1);
      left_d   = AB'(major_d) + AB'(1);
      radius_d = line_i.radius;
      active_d = 1'b1;
    end else if (advance_i && active_q) begin
      if (last) begin
        left_d   = '0;
        active_d = 1'b0;
      end else begin
        err_d  = minor_step ? err_sum - AB'(major_q) : err_sum;
        left_d = left_q - AB'(1);
        if (step_x) begin
          x_d = xneg_q ? x_q - CB'(1) : x_q + CB'(1);
        end
        if (step_y) begin
          y_d = yneg_q ? y_q - CB'(1) : y_q + CB'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q      <= '0;
      y_q      <= '0;
      err_q    <= '0;
      major_q  <= '0;
      minor_q  <= '0;
      left_q   <= '0;
      xneg_q   <= 1'b0;
      yneg_q   <= 1'b0;
      ymaj_q   <= 1'b0;
      radius_q <= '0;
      active_q <= 1'b0;
    end else begin
      x_q      <= x_d;
      y_q      <= y_d;
      err_q    <= err_d;
      major_q  <= major_d;
      minor_q  <= minor_d;
      left_q   <= left_d;
      xneg_q   <= xneg_d;
      yneg_q   <= yneg_d;
      ymaj_q   <= ymaj_d;
      radius_q <= radius_d;
      active_q <= active_d;
    end
  end

  assign status_o = '{active: active_q, last: last, x: x_q, y: y_q, radius: radius_q};

`ifndef NO_ASSERTIONS
  a_left_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> left_q != '0)
    else $error("active line with no points left");

  a_err_below_major: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (err_q < AB'(major_q) || major_q == '0))
    else $error("error accumulator out of range");

  a_last_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && !start_i && active_q && last) |=> !active_q)
    else $error("line still active after its last point");
`endif

endmodule

>>> design/thick_line_point_generator.sv
// Top level of the thick line point generator: config registers, walker and result register.
//
// This block walks a straight line between two endpoints with the Bresenham
// method and hands out one point per advance transfer. A start transfer
// (cmd 0) loads both endpoints and the brush radius and produces no result;
// a start while a line is running drops that line. Each advance transfer
// (cmd 1) produces the current point, then steps the walker toward the end
// point, so both endpoints are produced and the final one carries
// last_point. An advance while no line is running is consumed and produces
// nothing. Each point also carries visible, which is high when a circle of
// the brush radius around the point lies within screen_width by
// screen_height; points outside are still produced and the walk continues.
// Throughput is one input transfer per clock cycle: the walker state updates
// in the accepting cycle and the result lands in a single output register,
// valid in the cycle after. The input stalls only when that register holds a
// result and the output side is stalling. Configuration registers (index 0
// screen width, index 1 screen height, other indexes ignored) must be written
// only while the block is idle.
module thick_line_point_generator (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // Configuration write port.
  input  logic                                    cfg_we_i,
  input  logic [tlpg_pkg::CFG_INDEX_BITS-1:0]     cfg_index_i,
  input  logic [tlpg_pkg::CFG_BITS-1:0]           cfg_wdata_i,
  // Input channel.
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic                                    cmd_i,
  input  logic [tlpg_pkg::COORD_BITS-1:0]         start_x_i,
  input  logic [tlpg_pkg::COORD_BITS-1:0]         start_y_i,
  input  logic [tlpg_pkg::COORD_BITS-1:0]         end_x_i,
  input  logic [tlpg_pkg::COORD_BITS-1:0]         end_y_i,
  input  logic [tlpg_pkg::RADIUS_BITS-1:0]        brush_radius_i,
  // Output channel.
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic [tlpg_pkg::COORD_BITS-1:0]         point_x_o,
  output logic [tlpg_pkg::COORD_BITS-1:0]         point_y_o,
  output logic                                    visible_o,
  output logic                                    last_point_o
);

  logic [tlpg_pkg::CFG_BITS-1:0] width_q, height_q;

  logic                   in_accept;
  logic                   start;
  logic                   advance;
  logic                   emit;
  logic                   visible;
  tlpg_pkg::line_start_t  line;
  tlpg_pkg::walk_status_t status;

  logic                            out_valid_q, out_valid_d;
  logic [tlpg_pkg::COORD_BITS-1:0] px_q, py_q;
  logic                            vis_q, last_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= tlpg_pkg::ScreenWidthRst;
      height_q <= tlpg_pkg::ScreenHeightRst;
    end else if (cfg_we_i) begin
      if (cfg_index_i == tlpg_pkg::RegScreenWidth) begin
        width_q <= cfg_wdata_i;
      end
      if (cfg_index_i == tlpg_pkg::RegScreenHeight) begin
        height_q <= cfg_wdata_i;
      end
    end
  end

  // The input is held off only while a result waits and the sink stalls.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign start      = in_accept && (cmd_i == tlpg_pkg::CmdStart);
  assign advance    = in_accept && (cmd_i == tlpg_pkg::CmdAdvance);
  assign emit       = advance && status.active;

  assign line = '{x1: start_x_i, y1: start_y_i, x2: end_x_i, y2: end_y_i,
                  radius: brush_radius_i};

  tlpg_walker u_walker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .advance_i(advance),
    .line_i   (line),
    .status_o (status)
  );

  tlpg_bounds u_bounds (
    .x_i      (status.x),
    .y_i      (status.y),
    .radius_i (status.radius),
    .width_i  (width_q),
    .height_i (height_q),
    .visible_o(visible)
  );

  // Result register: a new result replaces one that is being taken this cycle.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      px_q   <= status.x;
      py_q   <= status.y;
      vis_q  <= visible;
      last_q <= status.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign point_x_o    = px_q;
  assign point_y_o    = py_q;
  assign visible_o    = vis_q;
  assign last_point_o = last_q;

`ifndef NO_ASSERTIONS
  a_emit_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_o)
    else $error("result transfer lost");

  a_start_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !(out_valid_q && out_stall_i)) |=> !out_valid_o)
    else $error("start transfer produced a result");
`endif

endmodule
